// ----- rtl/ils_pkg.sv -----
package ils_pkg;

  localparam int DefDepth = 256;
  localparam int PosW     = 13;
  localparam int DataW    = 32;

  localparam logic [3:0] ReqAppend = 4'd0;
  localparam logic [3:0] ReqRemove = 4'd1;
  localparam logic [3:0] ReqInsert = 4'd2;
  localparam logic [3:0] ReqErase  = 4'd3;
  localparam logic [3:0] ReqSwap   = 4'd4;
  localparam logic [3:0] ReqRead   = 4'd5;
  localparam logic [3:0] ReqFirst  = 4'd6;
  localparam logic [3:0] ReqLast   = 4'd7;
  localparam logic [3:0] ReqClear  = 4'd8;
  localparam logic [3:0] ReqWrite  = 4'd9;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_SWAP
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [PosW-1:0]        pos_a;
    logic [PosW-1:0]        pos_b;
    logic [DataW-1:0]       value;
    logic [DataW-1:0]       value_b;
  } cell_cmd_t;

endpackage

// ----- rtl/indexed_list_store.sv -----
// append, remove last, insert, erase, clear, write, unknown codes, rejected requests: result
//   strobe in the cycle after the transfer; accepted read, first, last and swap: scan state, then
//   fetch state, then result strobe; the scan lasts while the fetch walks one cell per cycle to
//   cell 0 from target, the position fetched (the larger one for swap); busy is high from the
//   transfer until the strobe; a new transfer can end the strobe cycle; the receiver cannot stall
// reset clears the count and control state; the store contents stay undefined, no clearing pass
module indexed_list_store #(
  parameter int DEPTH = ils_pkg::DefDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   req_type_i,
  input  logic [7:0]                   position_a_i,
  input  logic [7:0]                   position_b_i,
  input  logic signed [31:0]           value_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic signed [31:0]           read_value_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output logic                         is_empty_o
);
  import ils_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [3:0]       req_q, req_d;
  logic [PosW-1:0]  sel_a_q, sel_a_d, sel_b_q, sel_b_d, tgt_q, tgt_d, cnt_q, cnt_d;
  logic             done_q, done_d, ok_q, ok_d;
  logic [DataW-1:0] rv_q, rv_d;
  cell_cmd_t        cmd;

  logic [DataW-1:0] data_w    [DEPTH];
  logic [DataW-1:0] carry_a_w [DEPTH+1];
  logic [DataW-1:0] carry_b_w [DEPTH+1];

  logic [PosW-1:0]  pa_ext, pb_ext, cnt_ext;
  logic             full, empty, pa_ok, pb_ok, accept;

  assign pa_ext  = PosW'(position_a_i);
  assign pb_ext  = PosW'(position_b_i);
  assign cnt_ext = PosW'(count_q);
  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);
  assign pa_ok   = (pa_ext < cnt_ext);
  assign pb_ok   = (pb_ext < cnt_ext);
  assign accept  = start && (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    req_d     = req_q;
    sel_a_d   = sel_a_q;
    sel_b_d   = sel_b_q;
    tgt_d     = tgt_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    rv_d      = rv_q;
    cmd.op      = CELL_HOLD;
    cmd.pos_a   = sel_a_q;
    cmd.pos_b   = sel_b_q;
    cmd.value   = value_i;
    cmd.value_b = carry_b_w[0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d  = req_type_i;
          done_d = 1'b1;
          ok_d   = 1'b0;
          rv_d   = '1;
          cnt_d  = '0;
          case (req_type_i)
            ReqAppend: begin
              if (!full) begin
                cmd.op    = CELL_LOAD;
                cmd.pos_a = cnt_ext;
                count_d   = count_q + CntW'(1);
                ok_d      = 1'b1;
              end
            end
            ReqRemove: begin
              if (!empty) begin
                count_d = count_q - CntW'(1);
                ok_d    = 1'b1;
              end
            end
            ReqInsert: begin
              if (pa_ok && !full) begin
                cmd.op    = CELL_INSERT;
                cmd.pos_a = pa_ext;
                count_d   = count_q + CntW'(1);
                ok_d      = 1'b1;
              end
            end
            ReqErase: begin
              if (pa_ok) begin
                cmd.op    = CELL_ERASE;
                cmd.pos_a = pa_ext;
                count_d   = count_q - CntW'(1);
                ok_d      = 1'b1;
              end
            end
            ReqSwap: begin
              if (pa_ok && pb_ok) begin
                sel_a_d = pa_ext;
                sel_b_d = pb_ext;
                tgt_d   = (pa_ext > pb_ext) ? pa_ext : pb_ext;
                state_d = ST_SCAN;
                done_d  = 1'b0;
              end
            end
            ReqRead: begin
              if (pa_ok) begin
                sel_a_d = pa_ext;
                sel_b_d = pa_ext;
                tgt_d   = pa_ext;
                state_d = ST_SCAN;
                done_d  = 1'b0;
              end
            end
            ReqFirst: begin
              if (!empty) begin
                sel_a_d = '0;
                sel_b_d = '0;
                tgt_d   = '0;
                state_d = ST_SCAN;
                done_d  = 1'b0;
              end
            end
            ReqLast: begin
              if (!empty) begin
                sel_a_d = cnt_ext - PosW'(1);
                sel_b_d = cnt_ext - PosW'(1);
                tgt_d   = cnt_ext - PosW'(1);
                state_d = ST_SCAN;
                done_d  = 1'b0;
              end
            end
            ReqClear: begin
              count_d = '0;
              ok_d    = 1'b1;
            end
            ReqWrite: begin
              if (pa_ok) begin
                cmd.op    = CELL_LOAD;
                cmd.pos_a = pa_ext;
                ok_d      = 1'b1;
              end
            end
            default: ok_d = 1'b0;
          endcase
          if (ok_d) rv_d = '0;
          if (state_d == ST_IDLE) begin
            cmd.pos_b = cmd.pos_a;
          end else begin
            cmd.pos_a = sel_a_d;
            cmd.pos_b = sel_b_d;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + PosW'(1);
        if (cnt_q == tgt_q) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        done_d  = 1'b1;
        ok_d    = 1'b1;
        state_d = ST_IDLE;
        if (req_q == ReqSwap) begin
          cmd.op      = CELL_SWAP;
          cmd.value   = carry_a_w[0];
          cmd.value_b = carry_b_w[0];
          rv_d        = '0;
        end else begin
          rv_d = carry_a_w[0];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      req_q   <= ReqAppend;
      sel_a_q <= '0;
      sel_b_q <= '0;
      tgt_q   <= '0;
      ok_q    <= 1'b0;
      rv_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      req_q   <= req_d;
      sel_a_q <= sel_a_d;
      sel_b_q <= sel_b_d;
      tgt_q   <= tgt_d;
      ok_q    <= ok_d;
      rv_q    <= rv_d;
    end
  end

  assign carry_a_w[DEPTH] = '0;
  assign carry_b_w[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = data_w[g+1];
    end
    ils_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .left_i    (left_w),
      .right_i   (right_w),
      .carry_a_i (carry_a_w[g+1]),
      .carry_b_i (carry_b_w[g+1]),
      .data_o    (data_w[g]),
      .carry_a_o (carry_a_w[g]),
      .carry_b_o (carry_b_w[g])
    );
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign read_value_o = rv_q;
  assign count_o      = count_q;
  assign is_empty_o   = (count_q == '0);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("count above depth");

  a_sel_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(sel_a_q) && $stable(sel_b_q))
    else $error("fetch selects moved during scan");

  a_count_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q)) else $error("count changed without transfer");

endmodule

// ----- rtl/ils_cell.sv -----
module ils_cell #(
  parameter int INDEX = 0
) (
  input  logic                     clk_i,
  input  ils_pkg::cell_cmd_t       cmd_i,
  input  logic [ils_pkg::DataW-1:0] left_i,
  input  logic [ils_pkg::DataW-1:0] right_i,
  input  logic [ils_pkg::DataW-1:0] carry_a_i,
  input  logic [ils_pkg::DataW-1:0] carry_b_i,
  output logic [ils_pkg::DataW-1:0] data_o,
  output logic [ils_pkg::DataW-1:0] carry_a_o,
  output logic [ils_pkg::DataW-1:0] carry_b_o
);
  import ils_pkg::*;

  localparam logic [PosW-1:0] MyPos = PosW'(INDEX);

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] carry_a_q, carry_b_q;
  logic [PosW-1:0]  pos_a_next;
  logic             hit_a, hit_b;

  assign pos_a_next = cmd_i.pos_a + PosW'(1);
  assign hit_a      = (cmd_i.pos_a == MyPos);
  assign hit_b      = (cmd_i.pos_b == MyPos);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      CELL_LOAD: begin
        if (hit_a) data_d = cmd_i.value;
      end
      CELL_INSERT: begin
        if (MyPos == pos_a_next) data_d = cmd_i.value;
        else if (MyPos > pos_a_next) data_d = left_i;
      end
      CELL_ERASE: begin
        if (MyPos >= cmd_i.pos_a) data_d = right_i;
      end
      CELL_SWAP: begin
        if (hit_a) data_d = cmd_i.value_b;
        else if (hit_b) data_d = cmd_i.value;
      end
      default: data_d = data_q;
    endcase
  end

  // carries walk toward cell 0, a selected cell keeps injecting its entry
  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    carry_a_q <= hit_a ? data_q : carry_a_i;
    carry_b_q <= hit_b ? data_q : carry_b_i;
  end

  assign data_o    = data_q;
  assign carry_a_o = carry_a_q;
  assign carry_b_o = carry_b_q;

endmodule

// ----- verif/indexed_list_store_tb.sv -----
`timescale 1ns / 1ps

module indexed_list_store_tb;
  import ils_pkg::*;

  localparam int Depth = DefDepth;
  localparam int CntW = $clog2(Depth + 1);
  localparam int IdxW = $clog2(Depth);
  localparam logic signed [31:0] FailValue = -32'sd1;
  localparam logic [3:0] ReqTopCode = 4'hF;
  localparam int CycleLimit = 2_500_000;
  localparam int DrainCycles = 300;
  localparam int RandomItems = 1580;

  typedef struct {
    logic              ok;
    logic signed [31:0] read_value;
    logic [CntW-1:0]   count;
    logic              is_empty;
  } list_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] req_type_i = ReqAppend;
  logic [7:0] position_a_i = 8'd0;
  logic [7:0] position_b_i = 8'd0;
  logic signed [31:0] value_i = 32'sd0;
  logic done_o;
  logic ok_o;
  logic signed [31:0] read_value_o;
  logic [CntW-1:0] count_o;
  logic is_empty_o;

  logic signed [31:0] list_mem [Depth];
  int list_len = 0;
  int target_len = 16;
  list_answer_t answer_q [$];
  int mismatch_cnt = 0;
  int burst_left = 0;
  int cycle_cnt = 0;

  indexed_list_store u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .position_a_i (position_a_i),
    .position_b_i (position_b_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("TEST FAILED");
    $finish;
  end

  function automatic list_answer_t apply_list_request(input logic [3:0] kind,
                                                      input logic [7:0] pa,
                                                      input logic [7:0] pb,
                                                      input logic signed [31:0] val);
    list_answer_t a;
    int i;
    logic signed [31:0] t;
    a.ok = 1'b0;
    a.read_value = FailValue;
    case (kind)
      ReqAppend: begin
        if (list_len < Depth) begin
          list_mem[IdxW'(list_len)] = val;
          list_len++;
          a.ok = 1'b1;
        end
      end
      ReqRemove: begin
        if (list_len > 0) begin
          list_len--;
          a.ok = 1'b1;
        end
      end
      ReqInsert: begin
        if (int'(pa) < list_len && list_len < Depth) begin
          for (i = list_len; i > int'(pa) + 1; i--) list_mem[IdxW'(i)] = list_mem[IdxW'(i-1)];
          list_mem[IdxW'(int'(pa) + 1)] = val;
          list_len++;
          a.ok = 1'b1;
        end
      end
      ReqErase: begin
        if (int'(pa) < list_len) begin
          for (i = int'(pa); i + 1 < list_len; i++) list_mem[IdxW'(i)] = list_mem[IdxW'(i+1)];
          list_len--;
          a.ok = 1'b1;
        end
      end
      ReqSwap: begin
        if (int'(pa) < list_len && int'(pb) < list_len) begin
          t = list_mem[pa];
          list_mem[pa] = list_mem[pb];
          list_mem[pb] = t;
          a.ok = 1'b1;
        end
      end
      ReqRead: begin
        if (int'(pa) < list_len) begin
          a.read_value = list_mem[pa];
          a.ok = 1'b1;
        end
      end
      ReqFirst: begin
        if (list_len > 0) begin
          a.read_value = list_mem[0];
          a.ok = 1'b1;
        end
      end
      ReqLast: begin
        if (list_len > 0) begin
          a.read_value = list_mem[IdxW'(list_len-1)];
          a.ok = 1'b1;
        end
      end
      ReqClear: begin
        list_len = 0;
        a.ok = 1'b1;
      end
      ReqWrite: begin
        if (int'(pa) < list_len) begin
          list_mem[pa] = val;
          a.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (a.ok && kind != ReqRead && kind != ReqFirst && kind != ReqLast) a.read_value = 32'sd0;
    a.count = list_len[CntW-1:0];
    a.is_empty = (list_len == 0);
    return a;
  endfunction

  always @(posedge clk_i) begin
    list_answer_t exp_a;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: ok %0b value %0d count %0d empty %0b",
                   ok_o, read_value_o, count_o, is_empty_o);
        end
      end else begin
        exp_a = answer_q.pop_front();
        if (ok_o !== exp_a.ok || read_value_o !== exp_a.read_value ||
            count_o !== exp_a.count || is_empty_o !== exp_a.is_empty) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: ok %0b/%0b value %0d/%0d count %0d/%0d empty %0b/%0b",
                     exp_a.ok, ok_o, exp_a.read_value, read_value_o,
                     exp_a.count, count_o, exp_a.is_empty, is_empty_o);
          end
        end
      end
    end
  end

  // one transfer, then either stay in the burst or open a gap
  task automatic send_request(input logic [3:0] kind, input logic [7:0] pa,
                              input logic [7:0] pb, input logic signed [31:0] val);
    start <= 1'b1;
    req_type_i <= kind;
    position_a_i <= pa;
    position_b_i <= pb;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    answer_q.insert(answer_q.size(), apply_list_request(kind, pa, pb, val));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_answers();
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_position();
    if (list_len > 0 && $urandom_range(0, 99) < 85) return 8'($urandom_range(0, list_len - 1));
    if (list_len < Depth && $urandom_range(0, 1) == 0) return 8'($urandom_range(list_len, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return FailValue;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int r;
    bit grow;
    logic [3:0] kind;
    r = $urandom_range(0, 99);
    grow = (list_len < target_len);
    if (r < 2) kind = 4'($urandom_range(ReqWrite + 1, ReqTopCode));
    else if (r < 3) kind = ReqClear;
    else if (r < (grow ? 28 : 13)) kind = ReqAppend;
    else if (r < (grow ? 43 : 23)) kind = ReqInsert;
    else if (r < (grow ? 48 : 38)) kind = ReqErase;
    else if (r < (grow ? 53 : 48)) kind = ReqRemove;
    else if (r < 63) kind = ReqSwap;
    else if (r < 78) kind = ReqRead;
    else if (r < 83) kind = ReqFirst;
    else if (r < 88) kind = ReqLast;
    else kind = ReqWrite;
    send_request(kind, pick_position(), pick_position(), pick_value());
  endtask

  task automatic test_empty_list();
    send_request(ReqRemove, 8'd0, 8'd0, 32'sd0);
    send_request(ReqFirst, 8'd0, 8'd0, 32'sd0);
    send_request(ReqLast, 8'd0, 8'd0, 32'sd0);
    send_request(ReqRead, 8'd0, 8'd0, 32'sd0);
    send_request(ReqInsert, 8'd0, 8'd0, 32'sd5);
    send_request(ReqErase, 8'd0, 8'd0, 32'sd0);
    send_request(ReqSwap, 8'd0, 8'd0, 32'sd0);
    send_request(ReqWrite, 8'd0, 8'd0, 32'sd9);
  endtask

  task automatic test_directed_ops();
    send_request(ReqAppend, 8'd0, 8'd0, 32'sh7FFFFFFF);
    send_request(ReqAppend, 8'd255, 8'd255, 32'sh80000000);
    send_request(ReqAppend, 8'd0, 8'd0, FailValue);
    send_request(ReqAppend, 8'd0, 8'd0, 32'sd0);
    send_request(ReqInsert, 8'd3, 8'd0, 32'sd1);
    send_request(ReqInsert, 8'd0, 8'd0, 32'sh12345678);
    send_request(ReqSwap, 8'd1, 8'd1, 32'sd0);
    send_request(ReqSwap, 8'd0, 8'd5, 32'sd0);
    send_request(ReqRead, 8'd5, 8'd0, 32'sd0);
    send_request(ReqFirst, 8'd0, 8'd0, 32'sd0);
    send_request(ReqLast, 8'd0, 8'd0, 32'sd0);
    send_request(ReqWrite, 8'd2, 8'd0, 32'sh5A5A5A5A);
    send_request(ReqRead, 8'd255, 8'd0, 32'sd0);
    send_request(ReqErase, 8'd0, 8'd0, 32'sd0);
    send_request(ReqErase, 8'd4, 8'd0, 32'sd0);
    send_request(ReqRead, 8'd2, 8'd0, 32'sd0);
    send_request(ReqTopCode, 8'd0, 8'd0, 32'sd0);
    send_request(ReqClear, 8'd0, 8'd0, 32'sd0);
    send_request(ReqFirst, 8'd0, 8'd0, 32'sd0);
  endtask

  task automatic test_full_list();
    send_request(ReqClear, 8'd0, 8'd0, 32'sd0);
    while (list_len < Depth - 1) send_request(ReqAppend, pick_position(), 8'd0, $urandom);
    send_request(ReqInsert, 8'($urandom_range(0, list_len - 1)), 8'd0, $urandom);
    send_request(ReqAppend, 8'd0, 8'd0, 32'sd7);
    send_request(ReqInsert, 8'd0, 8'd0, 32'sd7);
    send_request(ReqRead, 8'd255, 8'd0, 32'sd0);
    send_request(ReqLast, 8'd0, 8'd0, 32'sd0);
    send_request(ReqSwap, 8'd0, 8'd255, 32'sd0);
    send_request(ReqFirst, 8'd0, 8'd0, 32'sd0);
    send_request(ReqWrite, 8'd255, 8'd0, 32'sh80000000);
    send_request(ReqRead, 8'd255, 8'd0, 32'sd0);
    send_request(ReqErase, 8'd255, 8'd0, 32'sd0);
    send_request(ReqAppend, 8'd0, 8'd0, FailValue);
    send_request(ReqErase, 8'd0, 8'd0, 32'sd0);
    send_request(ReqLast, 8'd0, 8'd0, 32'sd0);
  endtask

  task automatic test_random_mix();
    int n;
    for (n = 0; n < RandomItems; n++) begin
      if (n % 120 == 0) begin
        target_len = ($urandom_range(0, 7) == 0) ? Depth : $urandom_range(0, 96);
      end
      // hold off until the pipeline is empty
      if (n == RandomItems / 2) wait_answers();
      random_request();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_directed_ops();
    test_full_list();
    test_random_mix();
    wait_answers();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store.sv
verif/indexed_list_store_tb.sv
